// ----- src/mcpc_pkg.sv -----
// Shared constants, types and the fixed root table for the peak compressor.
package mcpc_pkg;

  localparam int LANES            = 8;
  localparam int IDX_W            = $clog2(LANES);
  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_SAMPLE_BITS  = 24;

  localparam int COEF_W = 25;
  localparam int CNT_W  = 4;
  localparam int CFG_W  = 25;
  localparam int ENV_W  = 32;
  localparam int GAIN_W = 23;

  localparam logic [1:0] CFG_ATTACK = 2'd0;
  localparam logic [1:0] CFG_DECAY  = 2'd1;
  localparam logic [1:0] CFG_COUNT  = 2'd2;

  localparam logic [COEF_W-1:0] COEF_ONE   = 25'd16777216;
  localparam logic [ENV_W-1:0]  ENV_RESET  = 32'd190941298;
  localparam logic [ENV_W-1:0]  ENV_LOW    = 32'd10737;
  localparam logic [ENV_W-1:0]  ENV_HIGH   = 32'd3395470;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 23'd65536;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 23'd5439488;

  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
  localparam logic [31:0] LOG2_10_Q28 = 32'd891723283;
  localparam logic [31:0] K3_Q24      = 32'd6442451;
  localparam logic [31:0] K2_Q24      = 32'd75833016;
  localparam logic [31:0] K1_Q24      = 32'd275146342;
  localparam logic [35:0] K0_Q28      = 36'd4563402752;

  // shared multiplier
  localparam int MUL_AW = 36;
  localparam int MUL_BW = 32;
  localparam int PROD_W = MUL_AW + MUL_BW;

  // divider for the high-level gain
  localparam int DIV_N_W   = 44;
  localparam int DIV_D_W   = 32;
  localparam int DIV_CNT_W = 6;

  localparam int FRAC_STEPS = 28;
  localparam int STEP_W     = 5;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quot;
  } div_stat_t;

  typedef logic [31:0] root_tab_t [FRAC_STEPS];

  function automatic logic [63:0] isqrt64(input logic [63:0] a);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bit_v;
    x     = a;
    res   = 64'd0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > x) bit_v = bit_v >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (x >= res + bit_v) begin
          x   = x - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-k) in Q2.30, k = 1..28, each the floor root of the one before
  function automatic root_tab_t calc_roots();
    root_tab_t   t;
    logic [63:0] root;
    root = 64'h8000_0000;
    for (int k = 0; k < FRAC_STEPS; k++) begin
      root = isqrt64(root << 30);
      t[k] = root[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOTS = calc_roots();

endpackage

// ----- src/mcpc_mul.sv -----
// Shared unsigned multiplier with a registered product.
module mcpc_mul
  import mcpc_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0] b,
  output logic [PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

// ----- src/mcpc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module mcpc_div
  import mcpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output div_stat_t          stat
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_D_W:0]     rem_r;
  logic [DIV_N_W-1:0]   quo_r;
  logic [DIV_D_W-1:0]   div_r;

  logic [DIV_D_W:0]     rem_sh;
  logic                 qbit;
  logic [DIV_D_W:0]     rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[DIV_D_W-1:0], quo_r[DIV_N_W-1]};
    qbit    = rem_sh >= {1'b0, div_r};
    rem_nxt = qbit ? rem_sh - {1'b0, div_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_N_W-2:0], qbit};
    end
  end

  assign stat.done = done_r;
  assign stat.quot = quo_r;

endmodule

// ----- src/multichannel_peak_compressor_core.sv -----
// From an input beat to its result the path depends on the envelope: low envelope, high envelope
// (divide), or the log/cubic/exp path; the next beat is taken after the result is registered.
// The frame sequencer runs every product through one shared multiplier;
// log2 takes 28 squarings, 2^x takes 28 root products. in_stall is high from accept until the
// result is in the output register, and while an untaken result still holds that register.
// Reset (synchronous, rst_n low): envelope to -15 dB, coefficients to one, two channels, empty.
module multichannel_peak_compressor_core
  import mcpc_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch0,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch1,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch2,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch3,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch4,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch5,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch6,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch7,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_ch0,
  output logic signed [SAMPLE_BITS-1:0] out_ch1,
  output logic signed [SAMPLE_BITS-1:0] out_ch2,
  output logic signed [SAMPLE_BITS-1:0] out_ch3,
  output logic signed [SAMPLE_BITS-1:0] out_ch4,
  output logic signed [SAMPLE_BITS-1:0] out_ch5,
  output logic signed [SAMPLE_BITS-1:0] out_ch6,
  output logic signed [SAMPLE_BITS-1:0] out_ch7,
  output logic [GAIN_W-1:0]             out_applied_gain
);

  localparam int SB    = SAMPLE_BITS;
  localparam int PSH_L = (SAMPLE_BITS <= 31) ? 31 - SAMPLE_BITS : 0;
  localparam int PSH_R = (SAMPLE_BITS > 31) ? SAMPLE_BITS - 31 : 0;
  localparam logic [CNT_W-1:0] ACT_MAX = CNT_W'(MAX_CHANNELS);
  localparam logic [PROD_W:0]  HALF    = (PROD_W + 1)'(1) << (SAMPLE_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_PEAK, S_ENV_MUL, S_ENV_UPD, S_NORM, S_LOG_MUL, S_LOG_UPD,
    S_U_MUL, S_U_UPD, S_U2_MUL, S_U2_UPD, S_U3_MUL, S_U3_UPD,
    S_P3_MUL, S_P3_UPD, S_P1_MUL, S_P1_UPD, S_P2_MUL, S_P2_UPD,
    S_W_MUL, S_W_UPD, S_EXP_MUL, S_EXP_UPD, S_GAIN, S_DIV_GO, S_DIV_WAIT,
    S_APPLY_MUL, S_APPLY_UPD, S_DONE
  } state_t;

  // registers
  state_t              state_r, state_nxt;
  logic [COEF_W-1:0]   attack_r, decay_r;
  logic [CNT_W-1:0]    count_r;
  logic [ENV_W-1:0]    env_r, env_nxt;
  logic [SB-1:0]       smp_r [LANES];
  logic [SB-1:0]       peak_r, peak_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                up_r, up_nxt;
  logic [31:0]         m_r, m_nxt;
  logic [4:0]          p_r, p_nxt;
  logic [27:0]         frac_r, frac_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [31:0]         u_r, u_nxt;
  logic [32:0]         u2_r, u2_nxt;
  logic [35:0]         u3_r, u3_nxt;
  logic [35:0]         pos_r, pos_nxt;
  logic [35:0]         neg_r, neg_nxt;
  logic [31:0]         r_r, r_nxt;
  logic [2:0]          n_r, n_nxt;
  logic [GAIN_W-1:0]   gain_r, gain_nxt;
  logic [SB-1:0]       res_r [LANES];
  logic [SB-1:0]       res_nxt [LANES];
  logic [SB-1:0]       oreg_r [LANES];
  logic [GAIN_W-1:0]   ogain_r;
  logic                out_valid_r;

  // datapath
  logic [MUL_AW-1:0]   mul_a;
  logic [MUL_BW-1:0]   mul_b;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W:0]     rnd15, rnd23, rnd27, rnd29;
  logic                div_start;
  logic [DIV_N_W-1:0]  div_num;
  div_stat_t           div_st;

  logic [CNT_W-1:0]    act;
  logic                idx_act;
  logic [SB-1:0]       sv;
  logic                sneg;
  logic [SB-1:0]       mag;
  logic [ENV_W-1:0]    peak_sc;
  logic [ENV_W-1:0]    dlt;
  logic [COEF_W-1:0]   coef;
  logic [ENV_W-1:0]    step_v;
  logic [31:0]         t_sq;
  logic [32:0]         v_log;
  logic [35:0]         e_v;
  logic [39:0]         w_v;
  logic [38:0]         g_sh;
  logic [24:0]         g_v;
  logic [PROD_W:0]     q_v, q_sat;
  logic [SB-1:0]       o_v;
  logic                out_take;

  mcpc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  assign div_num = (DIV_N_W'(ENV_RESET) << 16) + DIV_N_W'(env_r >> 1);

  mcpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (env_r),
    .stat     (div_st)
  );

  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    act     = (count_r > ACT_MAX) ? ACT_MAX : count_r;
    idx_act = (CNT_W'(idx_r) < act);
    sv      = smp_r[idx_r];
    sneg    = sv[SB-1];
    mag     = sneg ? (~sv + SB'(1)) : sv;
    peak_sc = ENV_W'(({{ENV_W{1'b0}}, peak_r} << PSH_L) >> PSH_R);
    up_nxt  = up_r;
    if (peak_sc > env_r) begin
      dlt  = peak_sc - env_r;
      coef = (attack_r > COEF_ONE) ? COEF_ONE : attack_r;
    end else begin
      dlt  = env_r - peak_sc;
      coef = (decay_r > COEF_ONE) ? COEF_ONE : decay_r;
    end
    rnd15  = {1'b0, prod} + (PROD_W + 1)'(1 << 15);
    rnd23  = {1'b0, prod} + (PROD_W + 1)'(1 << 23);
    rnd27  = {1'b0, prod} + (PROD_W + 1)'(1 << 27);
    rnd29  = {1'b0, prod} + (PROD_W + 1)'(1 << 29);
    step_v = rnd23[55:24];
    t_sq   = prod[61:30];
    v_log  = (33'd30 << 28) - ((33'(p_r) << 28) | 33'(frac_r));
    e_v    = (pos_r > neg_r) ? pos_r - neg_r : 36'd0;
    w_v    = rnd27[67:28];
    g_sh   = (39'(r_r) << n_r) + 39'(1 << 13);
    g_v    = g_sh[38:14];
    q_v    = rnd15 >> 16;
    if (sneg) begin
      q_sat = (q_v > HALF) ? HALF : q_v;
      o_v   = SB'(~q_sat + 1'b1);
    end else begin
      q_sat = (q_v > HALF - 1'b1) ? HALF - 1'b1 : q_v;
      o_v   = SB'(q_sat);
    end
    if (!idx_act) o_v = '0;

    state_nxt = state_r;
    env_nxt   = env_r;
    peak_nxt  = peak_r;
    idx_nxt   = idx_r;
    m_nxt     = m_r;
    p_nxt     = p_r;
    frac_nxt  = frac_r;
    step_nxt  = step_r;
    u_nxt     = u_r;
    u2_nxt    = u2_r;
    u3_nxt    = u3_r;
    pos_nxt   = pos_r;
    neg_nxt   = neg_r;
    r_nxt     = r_r;
    n_nxt     = n_r;
    gain_nxt  = gain_r;
    res_nxt   = res_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          peak_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = S_PEAK;
        end
      end
      S_PEAK: begin
        if (idx_act && mag > peak_r) peak_nxt = mag;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_W'(LANES - 1)) state_nxt = S_ENV_MUL;
      end
      S_ENV_MUL: begin
        up_nxt    = peak_sc > env_r;
        mul_a     = MUL_AW'(dlt);
        mul_b     = MUL_BW'(coef);
        state_nxt = S_ENV_UPD;
      end
      S_ENV_UPD: begin
        env_nxt = up_r ? env_r + step_v : env_r - step_v;
        idx_nxt = '0;
        if (env_nxt <= ENV_LOW) begin
          gain_nxt  = GAIN_ONE;
          state_nxt = S_APPLY_MUL;
        end else if (env_nxt >= ENV_HIGH) begin
          state_nxt = S_DIV_GO;
        end else begin
          m_nxt     = env_nxt;
          p_nxt     = 5'd30;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // walk the leading one up to bit 30
        if (m_r[30]) begin
          frac_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_LOG_MUL;
        end else begin
          m_nxt = m_r << 1;
          p_nxt = p_r - 1'b1;
        end
      end
      S_LOG_MUL: begin
        mul_a     = MUL_AW'(m_r);
        mul_b     = m_r;
        state_nxt = S_LOG_UPD;
      end
      S_LOG_UPD: begin
        frac_nxt = {frac_r[26:0], t_sq[31]};
        m_nxt    = t_sq[31] ? (t_sq >> 1) : t_sq;
        step_nxt = step_r + 1'b1;
        state_nxt = (step_r == STEP_W'(FRAC_STEPS - 1)) ? S_U_MUL : S_LOG_MUL;
      end
      S_U_MUL: begin
        mul_a     = MUL_AW'(v_log);
        mul_b     = LOG10_2_Q32;
        state_nxt = S_U_UPD;
      end
      S_U_UPD: begin
        u_nxt     = prod[63:32];
        state_nxt = S_U2_MUL;
      end
      S_U2_MUL: begin
        mul_a     = MUL_AW'(u_r);
        mul_b     = u_r;
        state_nxt = S_U2_UPD;
      end
      S_U2_UPD: begin
        u2_nxt    = rnd27[60:28];
        state_nxt = S_U3_MUL;
      end
      S_U3_MUL: begin
        mul_a     = MUL_AW'(u2_r);
        mul_b     = u_r;
        state_nxt = S_U3_UPD;
      end
      S_U3_UPD: begin
        u3_nxt    = rnd27[63:28];
        state_nxt = S_P3_MUL;
      end
      S_P3_MUL: begin
        mul_a     = u3_r;
        mul_b     = K3_Q24;
        state_nxt = S_P3_UPD;
      end
      S_P3_UPD: begin
        pos_nxt   = rnd23[59:24];
        state_nxt = S_P1_MUL;
      end
      S_P1_MUL: begin
        mul_a     = MUL_AW'(u_r);
        mul_b     = K1_Q24;
        state_nxt = S_P1_UPD;
      end
      S_P1_UPD: begin
        pos_nxt   = pos_r + rnd23[59:24];
        state_nxt = S_P2_MUL;
      end
      S_P2_MUL: begin
        mul_a     = MUL_AW'(u2_r);
        mul_b     = K2_Q24;
        state_nxt = S_P2_UPD;
      end
      S_P2_UPD: begin
        neg_nxt   = rnd23[59:24] + K0_Q28;
        state_nxt = S_W_MUL;
      end
      S_W_MUL: begin
        mul_a     = e_v;
        mul_b     = LOG2_10_Q28;
        state_nxt = S_W_UPD;
      end
      S_W_UPD: begin
        if (w_v[39:28] > 12'd6) begin
          gain_nxt  = GAIN_MAX;
          state_nxt = S_APPLY_MUL;
        end else begin
          n_nxt     = w_v[30:28];
          frac_nxt  = w_v[27:0];
          r_nxt     = 32'h4000_0000;
          step_nxt  = '0;
          state_nxt = S_EXP_MUL;
        end
      end
      S_EXP_MUL: begin
        mul_a     = MUL_AW'(r_r);
        mul_b     = ROOTS[step_r];
        state_nxt = S_EXP_UPD;
      end
      S_EXP_UPD: begin
        // fraction bits taken from the top down
        if (frac_r[STEP_W'(FRAC_STEPS - 1) - step_r]) r_nxt = rnd29[61:30];
        step_nxt  = step_r + 1'b1;
        state_nxt = (step_r == STEP_W'(FRAC_STEPS - 1)) ? S_GAIN : S_EXP_MUL;
      end
      S_GAIN: begin
        gain_nxt  = (g_v > 25'(GAIN_MAX)) ? GAIN_MAX : GAIN_W'(g_v);
        state_nxt = S_APPLY_MUL;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_st.done) begin
          gain_nxt  = (div_st.quot > DIV_N_W'(GAIN_MAX)) ? GAIN_MAX
                                                         : GAIN_W'(div_st.quot);
          state_nxt = S_APPLY_MUL;
        end
      end
      S_APPLY_MUL: begin
        mul_a     = MUL_AW'(mag);
        mul_b     = MUL_BW'(gain_r);
        state_nxt = S_APPLY_UPD;
      end
      S_APPLY_UPD: begin
        res_nxt[idx_r] = o_v;
        idx_nxt        = idx_r + 1'b1;
        state_nxt      = (idx_r == IDX_W'(LANES - 1)) ? S_DONE : S_APPLY_MUL;
      end
      S_DONE: begin
        if (!out_valid_r || out_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control, configuration and envelope
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      attack_r    <= COEF_ONE;
      decay_r     <= COEF_ONE;
      count_r     <= CNT_W'(2);
      env_r       <= ENV_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      env_r   <= env_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ATTACK: attack_r <= cfg_wdata[COEF_W-1:0];
          CFG_DECAY:  decay_r  <= cfg_wdata[COEF_W-1:0];
          CFG_COUNT:  count_r  <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && state_nxt == S_IDLE) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    peak_r <= peak_nxt;
    idx_r  <= idx_nxt;
    up_r   <= up_nxt;
    m_r    <= m_nxt;
    p_r    <= p_nxt;
    frac_r <= frac_nxt;
    step_r <= step_nxt;
    u_r    <= u_nxt;
    u2_r   <= u2_nxt;
    u3_r   <= u3_nxt;
    pos_r  <= pos_nxt;
    neg_r  <= neg_nxt;
    r_r    <= r_nxt;
    n_r    <= n_nxt;
    gain_r <= gain_nxt;
    res_r  <= res_nxt;
    if (state_r == S_IDLE && in_valid) begin
      smp_r[0] <= in_sample_ch0;
      smp_r[1] <= in_sample_ch1;
      smp_r[2] <= in_sample_ch2;
      smp_r[3] <= in_sample_ch3;
      smp_r[4] <= in_sample_ch4;
      smp_r[5] <= in_sample_ch5;
      smp_r[6] <= in_sample_ch6;
      smp_r[7] <= in_sample_ch7;
    end
    if (state_r == S_DONE && state_nxt == S_IDLE) begin
      oreg_r  <= res_r;
      ogain_r <= gain_r;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_ch0          = oreg_r[0];
  assign out_ch1          = oreg_r[1];
  assign out_ch2          = oreg_r[2];
  assign out_ch3          = oreg_r[3];
  assign out_ch4          = oreg_r[4];
  assign out_ch5          = oreg_r[5];
  assign out_ch6          = oreg_r[6];
  assign out_ch7          = oreg_r[7];
  assign out_applied_gain = ogain_r;

  // a beat taken on the input closes the port for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input port still open after a beat was taken");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_applied_gain <= GAIN_MAX))
    else $error("gain beyond its bound");

  // envelope never passes full scale
  a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= (ENV_W'(1) << 30))
    else $error("envelope beyond full scale");

endmodule
